// ----- rtl/uidot_pkg.sv -----
// Shared constants, types and helper functions of the unique-id order table.
package uidot_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam int ID_W        = 32;
    localparam int QTY_W       = 24;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int SUM_OUT_W   = 30;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ACC_W = QTY_W + $clog2(TABLE_DEPTH);

    localparam int CNT_CMP_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
    localparam int SUM_CMP_W = (ACC_W > SUM_OUT_W) ? ACC_W : SUM_OUT_W;
    localparam int COUNT_MAX = 2 ** COUNT_OUT_W - 1;
    localparam int SUM_MAX   = 2 ** SUM_OUT_W - 1;

    // stream payload layout
    localparam int S_TDATA_W = 2 * QTY_W + ID_W;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - COUNT_OUT_W - 2 * SUM_OUT_W;

    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STS_DONE      = 2'd0;
    localparam status_t STS_DUPLICATE = 2'd1;
    localparam status_t STS_NOT_FOUND = 2'd2;
    localparam status_t STS_FULL      = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    compare;
        logic    commit;
        logic    append;
        logic    remove;
        logic    clear;
        status_t status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic hit;
        logic full;
    } sts_t;

    // all bits at and above the single set bit of a one-hot vector
    function automatic logic [TABLE_DEPTH-1:0] prefix_or(input logic [TABLE_DEPTH-1:0] v);
        logic [TABLE_DEPTH-1:0] r;
        r = v;
        for (int s = 1; s < TABLE_DEPTH; s = s * 2) begin
            r = r | (r << s);
        end
        return r;
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        if (CNT_CMP_W'(c) > CNT_CMP_W'(COUNT_MAX)) begin
            return COUNT_OUT_W'(COUNT_MAX);
        end
        return COUNT_OUT_W'(c);
    endfunction

    function automatic logic [SUM_OUT_W-1:0] sat_sum(input logic [ACC_W-1:0] a);
        if (SUM_CMP_W'(a) > SUM_CMP_W'(SUM_MAX)) begin
            return SUM_OUT_W'(SUM_MAX);
        end
        return SUM_OUT_W'(a);
    endfunction

endpackage

// ----- rtl/unique_id_order_table.sv -----
// Top level of the unique-id order table: controller plus datapath.
//
//  channel  dir  tdata (low bit up)                       tuser
//  s_       in   order_id, order_quantity, order_outstand. operation
//  m_       out  entry_count, quantity_sum, total_outst.   status
//
// Each transfer passes through capture, parallel id compare across all
// entry cells, then commit (append, shift-down delete or clear) with the
// result loaded into the output register. Commit waits while an earlier
// result is still unclaimed on m_. Synchronous active-low reset empties
// the table; entry cells themselves are not cleared.
module unique_id_order_table (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // order_id[31:0], order_quantity[55:32], order_outstanding[79:56]
    input  logic [uidot_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[1:0]
    input  logic [uidot_pkg::OP_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // entry_count[6:0], quantity_sum[36:7], total_outstanding[66:37], zero pad
    output logic [uidot_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [uidot_pkg::STATUS_W-1:0]     m_tuser
);

    uidot_pkg::cmd_t cmd;
    uidot_pkg::sts_t sts;

    uidot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    uidot_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    a_action_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $onehot0({cmd.append, cmd.remove, cmd.clear}))
        else $error("more than one table action in one commit");

    a_action_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.remove |-> sts.hit) and (cmd.append |-> (!sts.hit && !sts.full)))
        else $error("table action disagrees with match status");

    a_capture_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (cmd.compare && !s_tready))
        else $error("compare did not follow input transfer");

    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("result not presented after commit");
`endif

endmodule

// ----- rtl/uidot_ctrl.sv -----
// Sequencing state machine of the order table: capture, compare, commit.
module uidot_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output uidot_pkg::cmd_t   cmd,
    input  uidot_pkg::sts_t   sts
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_MATCH  = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.status     = uidot_pkg::STS_DONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.compare = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                // wait here while the previous result is still unclaimed
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (sts.op)
                        uidot_pkg::OP_ADD: begin
                            if (sts.hit) begin
                                cmd.status = uidot_pkg::STS_DUPLICATE;
                            end else if (sts.full) begin
                                cmd.status = uidot_pkg::STS_FULL;
                            end else begin
                                cmd.append = 1'b1;
                            end
                        end
                        uidot_pkg::OP_DELETE: begin
                            if (sts.hit) begin
                                cmd.remove = 1'b1;
                            end else begin
                                cmd.status = uidot_pkg::STS_NOT_FOUND;
                            end
                        end
                        uidot_pkg::OP_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        default: begin
                            // unused code: report state unchanged
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ----- rtl/uidot_dp.sv -----
// Datapath of the order table: entry cells, id match, shift-down, count and sums.
module uidot_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [uidot_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [uidot_pkg::OP_W-1:0]          s_tuser,
    input  uidot_pkg::cmd_t                     cmd,
    output uidot_pkg::sts_t                     sts,
    output logic [uidot_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [uidot_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int DEPTH = uidot_pkg::TABLE_DEPTH;
    localparam int ID_W  = uidot_pkg::ID_W;
    localparam int QTY_W = uidot_pkg::QTY_W;
    localparam int CNT_W = uidot_pkg::CNT_W;
    localparam int ACC_W = uidot_pkg::ACC_W;

    // captured request
    uidot_pkg::op_t   op_reg;
    logic [ID_W-1:0]  key_reg;
    logic [QTY_W-1:0] add_qty_reg;
    logic [QTY_W-1:0] add_outq_reg;

    // entry cells
    logic [ID_W-1:0]  ids_reg  [DEPTH];
    logic [ID_W-1:0]  ids_next [DEPTH];
    logic [QTY_W-1:0] qty_reg  [DEPTH];
    logic [QTY_W-1:0] qty_next [DEPTH];
    logic [QTY_W-1:0] outq_reg  [DEPTH];
    logic [QTY_W-1:0] outq_next [DEPTH];

    logic [DEPTH-1:0] match_reg, match_next;
    logic [DEPTH-1:0] shift_mask;
    logic [QTY_W-1:0] rem_qty, rem_outq;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [ACC_W-1:0] vol_reg, vol_next;
    logic [ACC_W-1:0] outs_reg, outs_next;

    uidot_pkg::status_t                      status_reg;
    logic [uidot_pkg::COUNT_OUT_W-1:0]       count_out_reg;
    logic [uidot_pkg::SUM_OUT_W-1:0]         vol_out_reg;
    logic [uidot_pkg::SUM_OUT_W-1:0]         outs_out_reg;

    // each cell compares its own id; ids are unique so at most one bit is set
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match_next[i] = (ids_reg[i] == key_reg) && (CNT_W'(i) < fill_reg);
        end
    end

    assign shift_mask = uidot_pkg::prefix_or(match_reg);

    // pick out the quantities of the matching entry
    always_comb begin
        rem_qty  = '0;
        rem_outq = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rem_qty  = rem_qty  | (qty_reg[i]  & {QTY_W{match_reg[i]}});
            rem_outq = rem_outq | (outq_reg[i] & {QTY_W{match_reg[i]}});
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ids_next[i]  = ids_reg[i];
            qty_next[i]  = qty_reg[i];
            outq_next[i] = outq_reg[i];
        end
        if (cmd.commit && cmd.remove) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (shift_mask[i]) begin
                    ids_next[i]  = ids_reg[i+1];
                    qty_next[i]  = qty_reg[i+1];
                    outq_next[i] = outq_reg[i+1];
                end
            end
        end
        if (cmd.commit && cmd.append) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (fill_reg == CNT_W'(i)) begin
                    ids_next[i]  = key_reg;
                    qty_next[i]  = add_qty_reg;
                    outq_next[i] = add_outq_reg;
                end
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        vol_next  = vol_reg;
        outs_next = outs_reg;
        if (cmd.commit) begin
            if (cmd.append) begin
                fill_next = fill_reg + CNT_W'(1);
                vol_next  = vol_reg  + ACC_W'(add_qty_reg);
                outs_next = outs_reg + ACC_W'(add_outq_reg);
            end else if (cmd.remove) begin
                fill_next = fill_reg - CNT_W'(1);
                vol_next  = vol_reg  - ACC_W'(rem_qty);
                outs_next = outs_reg - ACC_W'(rem_outq);
            end else if (cmd.clear) begin
                fill_next = '0;
                vol_next  = '0;
                outs_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            vol_reg  <= '0;
            outs_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            vol_reg  <= vol_next;
            outs_reg <= outs_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            ids_reg[i]  <= ids_next[i];
            qty_reg[i]  <= qty_next[i];
            outq_reg[i] <= outq_next[i];
        end
        if (cmd.capture) begin
            op_reg       <= s_tuser;
            key_reg      <= s_tdata[ID_W-1:0];
            add_qty_reg  <= s_tdata[ID_W+QTY_W-1:ID_W];
            add_outq_reg <= s_tdata[ID_W+2*QTY_W-1:ID_W+QTY_W];
        end
        if (cmd.compare) begin
            match_reg <= match_next;
        end
        if (cmd.commit) begin
            status_reg    <= cmd.status;
            count_out_reg <= uidot_pkg::sat_count(fill_next);
            vol_out_reg   <= uidot_pkg::sat_sum(vol_next);
            outs_out_reg  <= uidot_pkg::sat_sum(outs_next);
        end
    end

    assign sts.op   = op_reg;
    assign sts.hit  = |match_reg;
    assign sts.full = (fill_reg == CNT_W'(DEPTH));

    assign m_tdata = {{uidot_pkg::M_PAD_W{1'b0}}, outs_out_reg, vol_out_reg, count_out_reg};
    assign m_tuser = status_reg;

endmodule
